// ===== rtl/wtb_pkg.sv =====
// ----------------------------------------------------------------------------
// wtb_pkg
// Shared types and character codes for the whitespace-to-HTML-breaks block.
// ----------------------------------------------------------------------------
package wtb_pkg;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_B     = 8'h42;  // 'B'
    localparam logic [7:0] CH_R     = 8'h52;  // 'R'
    localparam logic [7:0] CH_P     = 8'h50;  // 'P'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'

    // Most result beats that one input byte can cause: "<BR>" plus the byte.
    localparam int unsigned MAX_BEATS = 5;
    localparam int unsigned CNT_W     = 3;

    // The burst of result beats that one input byte produces.
    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;     // number of beats, 1 to MAX_BEATS
        logic                      last;    // final beat closes the string
        logic                      nochar;  // single empty beat, no character
    } plan_t;

    // Status of the output stage, seen by the top level.
    typedef struct packed {
        logic busy;        // a burst is held
        logic final_beat;  // the beat on offer is the last of its burst
    } ser_status_t;

endpackage

// ===== rtl/whitespace_to_html_breaks.sv =====
// ----------------------------------------------------------------------------
// whitespace_to_html_breaks
// Rewrites a text string for HTML: collapses blank runs, turns newlines
// into <BR> and <P> tags.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_byte, in_last) takes one
// character per beat; in_last marks the final character of a string. The
// result channel (res_valid, res_stall, out_byte, out_valid, out_last)
// gives the rewritten text one character per beat. out_valid is low only
// on the single empty beat sent when the final character of a string
// produces nothing; out_last marks the final beat of each string.
// An accepted character is decoded in the same cycle and its burst of one
// to five result beats is registered, so the first beat appears in the cycle
// after acceptance. A character that gives one beat is taken every cycle
// while the receiver does not stall; one that expands to a tag holds the
// input until its last beat leaves the single burst register that feeds
// the result channel. Characters that vanish entirely give no beat.
// When the receiver stalls, the held beat stays on the ports and the input
// is stalled once the burst register cannot be freed in that cycle.
// Reset clears the newline and blank-run state and empties the output.
// ----------------------------------------------------------------------------
module whitespace_to_html_breaks
    import wtb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_last
);

    plan_t       plan;
    logic        load;
    logic        free;
    logic        accept;
    ser_status_t status;

    // A new character may enter whenever the burst register is, or is
    // about to become, empty.
    assign in_stall = !free;
    assign accept   = in_valid && free;

    wtb_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .plan    (plan),
        .load    (load)
    );

    wtb_serial u_serial
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .plan      (plan),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_last  (out_last),
        .status    (status),
        .free      (free)
    );

    // The input is only ever held back by a burst still being sent.
    a_stall_needs_burst: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> res_valid)
        else $error("input stalled with no burst held");

    // An empty beat stands alone and closes its string.
    a_empty_beat_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> (status.final_beat && out_last && out_byte == 8'd0))
        else $error("empty beat is not a lone closing beat");

    // After the last beat of a burst leaves, a new burst appears only if a
    // character was accepted in that cycle.
    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && status.final_beat && !accept) |=> !status.busy)
        else $error("burst register stayed busy after its final beat");

endmodule

// ===== rtl/wtb_decode.sv =====
// ----------------------------------------------------------------------------
// wtb_decode
// Holds the whitespace state and works out the burst for each accepted byte.
// ----------------------------------------------------------------------------
module wtb_decode
    import wtb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output plan_t      plan,
    output logic       load
);

    logic nl_pending_reg, nl_pending_next;
    logic skipping_reg,   skipping_next;
    logic after_sp_reg,   after_sp_next;
    logic after_tab_reg,  after_tab_next;

    logic is_nl, is_blank;
    logic keep0, keep1, keep2;
    logic emit_p, emit_br_pre, emit_byte, emit_br_post;
    logic [CNT_W-1:0] n;

    always_comb
    begin
        is_nl    = (in_byte == CH_LF) || (in_byte == CH_CR);
        is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

        // Collapse runs of spaces and runs of tabs.
        keep0 = !(((in_byte == CH_SPACE) && after_sp_reg) ||
                  ((in_byte == CH_TAB) && after_tab_reg));
        after_sp_next  = (in_byte == CH_SPACE);
        after_tab_next = (in_byte == CH_TAB);

        // After a paragraph break, drop newlines and blanks.
        skipping_next = skipping_reg;
        keep1         = keep0;
        if (keep0 && skipping_reg)
        begin
            if (is_nl || is_blank)
                keep1 = 1'b0;
            else
                skipping_next = 1'b0;
        end

        // Resolve a held newline.
        nl_pending_next = nl_pending_reg;
        emit_p          = 1'b0;
        emit_br_pre     = 1'b0;
        keep2           = keep1;
        if (keep1 && nl_pending_reg)
        begin
            nl_pending_next = 1'b0;
            if (is_nl)
            begin
                emit_p        = 1'b1;
                skipping_next = 1'b1;
                keep2         = 1'b0;
            end
            else
            begin
                emit_br_pre = 1'b1;
            end
        end

        emit_byte = 1'b0;
        if (keep2)
        begin
            if (is_nl)
                nl_pending_next = 1'b1;
            else
                emit_byte = 1'b1;
        end

        emit_br_post = in_last && nl_pending_next;

        // Lay the burst out in order.
        plan.bytes = '0;
        n          = '0;
        if (emit_p)
        begin
            plan.bytes[0] = CH_LT;
            plan.bytes[1] = CH_P;
            plan.bytes[2] = CH_GT;
            n             = CNT_W'(3);
        end
        if (emit_br_pre || emit_br_post)
        begin
            // The two never coincide, and neither follows a paragraph tag.
            plan.bytes[0] = CH_LT;
            plan.bytes[1] = CH_B;
            plan.bytes[2] = CH_R;
            plan.bytes[3] = CH_GT;
            n             = CNT_W'(4);
        end
        if (emit_byte)
        begin
            plan.bytes[n] = in_byte;
            n             = n + CNT_W'(1);
        end

        plan.nochar = in_last && (n == '0);
        plan.cnt    = plan.nochar ? CNT_W'(1) : n;
        plan.last   = in_last;
        load        = accept && ((n != '0) || in_last);

        // The end of a string returns everything to the idle state.
        if (in_last)
        begin
            nl_pending_next = 1'b0;
            skipping_next   = 1'b0;
            after_sp_next   = 1'b0;
            after_tab_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_pending_reg <= 1'b0;
            skipping_reg   <= 1'b0;
            after_sp_reg   <= 1'b0;
            after_tab_reg  <= 1'b0;
        end
        else if (accept)
        begin
            nl_pending_reg <= nl_pending_next;
            skipping_reg   <= skipping_next;
            after_sp_reg   <= after_sp_next;
            after_tab_reg  <= after_tab_next;
        end
    end

endmodule

// ===== rtl/wtb_serial.sv =====
// ----------------------------------------------------------------------------
// wtb_serial
// Holds one burst and hands it out a beat at a time on the result channel.
// ----------------------------------------------------------------------------
module wtb_serial
    import wtb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  plan_t       plan,
    input  logic        res_stall,
    output logic        res_valid,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic        out_last,
    output ser_status_t status,
    output logic        free
);

    plan_t            plan_reg;
    logic             busy_reg,  busy_next;
    logic [CNT_W-1:0] idx_reg,   idx_next;
    logic             fire, final_beat;

    always_comb
    begin
        final_beat = (idx_reg == (plan_reg.cnt - CNT_W'(1)));
        fire       = busy_reg && !res_stall;
        // The slot frees in the cycle its last beat leaves.
        free       = !busy_reg || (fire && final_beat);

        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (fire)
        begin
            if (final_beat)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end

        res_valid         = busy_reg;
        out_byte          = plan_reg.nochar ? 8'd0 : plan_reg.bytes[idx_reg];
        out_valid         = !plan_reg.nochar;
        out_last          = plan_reg.last && final_beat;
        status.busy       = busy_reg;
        status.final_beat = final_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            plan_reg <= plan;
    end

endmodule

// ===== tb/tb_whitespace_to_html_breaks.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_whitespace_to_html_breaks
// Self-checking bench for the whitespace-to-HTML-breaks rewriter.
//
// Strings are fed one character per beat. A behavioural copy of the rewrite
// rules predicts the result beats of every accepted character, and each
// result beat is checked against the oldest prediction. Both sides stall
// at random. A short directed set of strings comes first, then random
// strings rich in blanks and newlines.
// ----------------------------------------------------------------------------
module tb_whitespace_to_html_breaks;
    import wtb_pkg::*;

    // One character waiting to be sent.
    typedef struct {
        logic [7:0] ch;
        logic       lst;
    } text_char_t;

    // One result beat that the block should produce.
    typedef struct {
        logic [7:0] ch;
        logic       vld;
        logic       lst;
    } html_beat_t;

    typedef logic [7:0] char_list_t[$];

    localparam int unsigned STUCK_LIMIT  = 5000;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned TARGET_CHARS = 470;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h01;
    logic       in_last = 1'b0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;

    // Characters still to be driven, and beats still to be received.
    text_char_t src_chars[$];
    html_beat_t html_due[$];

    // Rewrite state of the predictor; a string's end clears all of it.
    logic nl_held = 1'b0;
    logic skip_blanks = 1'b0;
    logic prev_space = 1'b0;
    logic prev_tab = 1'b0;

    int unsigned chars_taken = 0;
    int unsigned stuck_cycles = 0;
    int unsigned fails = 0;
    int unsigned queued = 0;

    // Randomised idling and result stalls are switched off for a stretch in the middle of the run.
    logic quiet;
    assign quiet = (chars_taken >= 200) && (chars_taken < 300);

    whitespace_to_html_breaks DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_last  (out_last)
    );

    always #4 clk = ~clk;

    function automatic logic is_newline(logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic void due_char(logic [7:0] c);
        html_beat_t beat;
        beat.ch  = c;
        beat.vld = 1'b1;
        beat.lst = 1'b0;
        html_due.push_back(beat);
    endfunction

    function automatic void due_break();
        due_char(CH_LT);
        due_char(CH_B);
        due_char(CH_R);
        due_char(CH_GT);
    endfunction

    // Works out the result beats of one accepted character and appends them
    // to the list of beats due.
    function automatic void rewrite_char(logic [7:0] c, logic lst);
        int unsigned start_size;
        logic        keep;
        html_beat_t  empty_beat;
        start_size = html_due.size();
        keep = 1'b1;

        // A blank that repeats the previous blank of the same kind vanishes.
        if ((c == CH_SPACE && prev_space) || (c == CH_TAB && prev_tab))
            keep = 1'b0;
        prev_space = (c == CH_SPACE);
        prev_tab   = (c == CH_TAB);

        // After a paragraph tag, newlines and blanks are swallowed until
        // some other character turns up.
        if (keep && skip_blanks)
        begin
            if (is_newline(c) || c == CH_SPACE || c == CH_TAB)
                keep = 1'b0;
            else
                skip_blanks = 1'b0;
        end

        // A held newline is resolved by the character that follows it.
        if (keep && nl_held)
        begin
            nl_held = 1'b0;
            if (is_newline(c))
            begin
                due_char(CH_LT);
                due_char(CH_P);
                due_char(CH_GT);
                skip_blanks = 1'b1;
                keep = 1'b0;
            end
            else
            begin
                due_break();
            end
        end

        if (keep)
        begin
            if (is_newline(c))
                nl_held = 1'b1;
            else
                due_char(c);
        end

        if (lst)
        begin
            if (nl_held)
                due_break();
            if (html_due.size() == start_size)
            begin
                // Nothing survived, so the string closes with an empty beat.
                empty_beat.ch  = 8'h00;
                empty_beat.vld = 1'b0;
                empty_beat.lst = 1'b1;
                html_due.push_back(empty_beat);
            end
            else
            begin
                html_due[html_due.size() - 1].lst = 1'b1;
            end
            nl_held     = 1'b0;
            skip_blanks = 1'b0;
            prev_space  = 1'b0;
            prev_tab    = 1'b0;
        end
    endfunction

    function automatic void send_string(char_list_t s);
        text_char_t item;
        foreach (s[i])
        begin
            item.ch  = s[i];
            item.lst = (i == s.size() - 1);
            src_chars.push_back(item);
        end
        queued += s.size();
    endfunction

    // Random characters lean heavily on blanks and newlines so that the
    // collapsing and tag rules are exercised often.
    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return CH_SPACE;
        else if (r < 25)
            return CH_TAB;
        else if (r < 40)
            return CH_LF;
        else if (r < 50)
            return CH_CR;
        else
            return 8'($urandom_range(1, 255));
    endfunction

    function automatic void send_random_string();
        char_list_t s;
        int unsigned len;
        if ($urandom_range(0, 19) == 0)
            len = $urandom_range(20, 40);
        else
            len = $urandom_range(1, 10);
        repeat (len)
            s.push_back(pick_char());
        send_string(s);
    endfunction

    // Waits until every queued character has gone in and every predicted
    // beat has come out.
    task automatic drain();
        while (src_chars.size() != 0 || html_due.size() != 0)
            @(posedge clk);
    endtask

    // Driver: offers the head of the character queue, holding it steady
    // while the block stalls, and idles at random between beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h01;
            in_last  <= 1'b0;
        end
        else
        begin : drive
            logic taken;
            logic offer;
            taken = in_valid && !in_stall;
            if (taken)
            begin
                rewrite_char(in_byte, in_last);
                void'(src_chars.pop_front());
                chars_taken <= chars_taken + 1;
            end
            if (!in_valid || taken)
            begin
                offer = (src_chars.size() != 0) && (quiet || $urandom_range(0, 99) >= 8);
                in_valid <= offer;
                if (offer)
                begin
                    in_byte <= src_chars[0].ch;
                    in_last <= src_chars[0].lst;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction and
    // stalls the result channel at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin : watch
            html_beat_t want;
            if (res_valid && !res_stall)
            begin
                if (html_due.size() == 0)
                begin
                    $error("result beat with nothing due: out_byte %0d, out_valid %0b, out_last %0b",
                           out_byte, out_valid, out_last);
                    fails++;
                end
                else
                begin
                    want = html_due.pop_front();
                    if (out_byte !== want.ch)
                    begin
                        $error("out_byte: expected %0d, got %0d", want.ch, out_byte);
                        fails++;
                    end
                    if (out_valid !== want.vld)
                    begin
                        $error("out_valid: expected %0b, got %0b", want.vld, out_valid);
                        fails++;
                    end
                    if (out_last !== want.lst)
                    begin
                        $error("out_last: expected %0b, got %0b", want.lst, out_last);
                        fails++;
                    end
                end
            end
            res_stall <= !quiet && ($urandom_range(0, 99) < 8);
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (res_valid && !res_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed strings: blank runs, lone and doubled newlines, blanks
        // after a paragraph, a newline closing the string, a dropped final
        // character and the extreme character codes.
        send_string('{8'h61, CH_SPACE, CH_SPACE, 8'h62});
        send_string('{CH_TAB, CH_TAB, CH_TAB});
        send_string('{CH_LF, 8'h78});
        send_string('{CH_CR, CH_LF, CH_SPACE, CH_TAB, 8'h79});
        send_string('{CH_LF});
        send_string('{CH_CR, CH_CR});
        send_string('{CH_CR, CH_SPACE});
        send_string('{8'hFF, 8'h01});
        send_string('{CH_SPACE, CH_LF, CH_LF, CH_CR});

        // Hold the sender back until the directed part has fully drained.
        drain();

        @(negedge clk);
        while (queued < TARGET_CHARS / 2)
            send_random_string();
        drain();

        @(negedge clk);
        while (queued < TARGET_CHARS)
            send_random_string();
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0 && html_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
